// File: hdl/spc_pkg.sv
package spc_pkg;

  // Design constants
  localparam int MOTOR_COUNT  = 2;
  localparam int COUNT_WIDTH  = 16;
  localparam int MOTOR_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int ERR_W        = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
  localparam int SUM_W        = ERR_W + 1;
  localparam int INTEG_W      = 12;
  localparam int INTEGRAL_MAX = 3200;
  localparam int OUT_SHIFT    = 5;
  localparam int DUTY_MAX     = 100;
  localparam int QUEUE_DEPTH  = 2;

  // Item kinds
  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_PERIOD = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_TARGET0 = 2'd0;
  localparam logic [1:0] REG_TARGET1 = 2'd1;
  localparam logic [1:0] REG_GAIN_P  = 2'd2;
  localparam logic [1:0] REG_GAIN_I  = 2'd3;

  // Decoded command held in the queue
  typedef struct packed {
    logic is_period;
    logic motor;
  } cmd_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Configuration values
  typedef struct packed {
    logic [15:0] target0;
    logic [15:0] target1;
    logic [7:0]  gain_p;
    logic [7:0]  gain_i;
  } cfg_t;

endpackage

// File: hdl/spc_front.sv
module spc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic          in_motor,
  output spc_pkg::head_t head,
  input  logic          pop
);
  import spc_pkg::*;

  cmd_t       entry_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       accept;
  logic       keep;
  logic       push;
  cmd_t       cmd;

  // The queue is full when both entries hold a word.
  assign in_stall = (count_r == 2'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // Classify the word; edges for a motor that does not exist cause nothing and are dropped.
  assign cmd.is_period = (in_kind == KIND_PERIOD);
  assign cmd.motor     = in_motor;
  assign keep          = cmd.is_period || (32'(in_motor) < MOTOR_COUNT);
  assign push          = accept && keep;

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = entry_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// File: hdl/spc_back.sv
module spc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spc_pkg::head_t        head,
  output logic                  pop,
  input  spc_pkg::cfg_t         cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_motor_index,
  output logic [6:0]            out_duty,
  output logic signed [16:0]    out_speed_error,
  output logic                  out_last
);
  import spc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [MOTOR_W-1:0]     motor_r;
  logic [MOTOR_W-1:0]     motor_nxt;
  logic [COUNT_WIDTH-1:0] tick_r [MOTOR_COUNT];
  logic [INTEG_W-1:0]     esum_r [MOTOR_COUNT];
  logic [MOTOR_W-1:0]     idx;
  logic [COUNT_WIDTH-1:0] ticks;
  logic [15:0]            target;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W-1:0] sum;
  logic [INTEG_W-1:0]     sum_clamped;
  logic signed [ERR_W-1:0] err_r;
  logic [INTEG_W-1:0]     integ_r;
  logic [15:0]            prod_i_r;
  logic [15:0]            prod_p_r;
  logic [15:0]            raw;
  logic signed [15:0]     shifted;
  logic [6:0]             duty;
  logic                   is_last;
  logic                   out_free;
  logic                   out_valid_r;
  logic                   out_motor_r;
  logic [6:0]             out_duty_r;
  logic [16:0]            out_err_r;
  logic                   out_last_r;

  // One read port on the per-motor state: the queued edge while idle, the current motor otherwise.
  assign idx   = (state_r == ST_IDLE) ? MOTOR_W'(head.cmd.motor) : motor_r;
  assign ticks = tick_r[idx];

  assign pop      = (state_r == ST_IDLE) && head.valid;
  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (32'(motor_r) == MOTOR_COUNT - 1);

  // Error and clamped integral for the current motor.
  always_comb begin
    target = (motor_r == '0) ? cfg.target0 : cfg.target1;
    err    = $signed(ERR_W'(target)) - $signed(ERR_W'(ticks));
    sum    = $signed(SUM_W'(esum_r[idx])) + SUM_W'(err);
    if (sum < 0) begin
      sum_clamped = '0;
    end else if (sum > SUM_W'(INTEGRAL_MAX)) begin
      sum_clamped = INTEG_W'(INTEGRAL_MAX);
    end else begin
      sum_clamped = sum[INTEG_W-1:0];
    end
  end

  // Only the low 16 bits of the controller output matter, so the products are kept at 16 bits.
  always_comb begin
    raw     = prod_i_r + prod_p_r;
    shifted = $signed(raw) >>> OUT_SHIFT;
    if (shifted < 0) begin
      duty = 7'd0;
    end else if (shifted > 16'(DUTY_MAX)) begin
      duty = 7'(DUTY_MAX);
    end else begin
      duty = shifted[6:0];
    end
  end

  // Sequencer: an edge is handled in the idle cycle, a period tick walks the motors.
  always_comb begin
    state_nxt = state_r;
    motor_nxt = motor_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid && head.cmd.is_period) begin
          motor_nxt = '0;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            motor_nxt = motor_r + MOTOR_W'(1);
            state_nxt = ST_ERR;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      motor_r <= '0;
    end else begin
      state_r <= state_nxt;
      motor_r <= motor_nxt;
    end
  end

  // Tick counters and integrals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        tick_r[i] <= '0;
        esum_r[i] <= '0;
      end
    end else if (pop && !head.cmd.is_period) begin
      if (ticks != '1) begin
        tick_r[idx] <= ticks + COUNT_WIDTH'(1);
      end
    end else if (state_r == ST_ERR) begin
      tick_r[idx] <= '0;
      esum_r[idx] <= sum_clamped;
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk) begin
    if (state_r == ST_ERR) begin
      err_r   <= err;
      integ_r <= sum_clamped;
    end
    if (state_r == ST_MUL) begin
      prod_i_r <= 16'(cfg.gain_i * 16'(integ_r));
      prod_p_r <= 16'(cfg.gain_p * err_r[15:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_motor_r <= motor_r[0];
      out_duty_r  <= duty;
      out_err_r   <= err_r[16:0];
      out_last_r  <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_index = out_motor_r;
  assign out_duty        = out_duty_r;
  assign out_speed_error = $signed(out_err_r);
  assign out_last        = out_last_r;

endmodule

// File: hdl/encoder_pi_speed_control.sv
// Two-motor PI speed regulator. Input words are encoder edges (kind 0, with the motor
// number) or control period ticks (kind 1). An edge adds one to that motor's saturating
// tick counter and gives no result; a period tick gives one result word per motor, motor 0
// first, with last set on the final one. Words pass through a two-word queue into a
// sequencer: an edge is handled in the idle state, and a period tick is dispatched from the
// idle state and then walks, for each motor, the error and integral, gain product and output
// states, holding in the output state while the result side stalls. The configuration port is
// always ready; write it only while no period tick is being processed.
module encoder_pi_speed_control (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic               in_motor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_motor_index,
  output logic [6:0]         out_duty,
  output logic signed [16:0] out_speed_error,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import spc_pkg::*;

  head_t head;
  logic  pop;
  cfg_t  cfg_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target0 <= 16'd100;
      cfg_r.target1 <= 16'd100;
      cfg_r.gain_p  <= 8'd0;
      cfg_r.gain_i  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET0: cfg_r.target0 <= cfg_data;
        REG_TARGET1: cfg_r.target1 <= cfg_data;
        REG_GAIN_P:  cfg_r.gain_p  <= cfg_data[7:0];
        REG_GAIN_I:  cfg_r.gain_i  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  spc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_motor (in_motor),
    .head     (head),
    .pop      (pop)
  );

  spc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_motor_index (out_motor_index),
    .out_duty        (out_duty),
    .out_speed_error (out_speed_error),
    .out_last        (out_last)
  );

endmodule

// File: hdl/spc_checker.sv
module spc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_motor_index,
  input logic [6:0]         out_duty,
  input logic               out_last
);
  import spc_pkg::*;

  // A stalled result word stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // The duty is always clamped to the percent range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty <= 7'(DUTY_MAX))
    else $error("duty above its maximum");

  // The final word of a period belongs to the last motor.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_motor_index == 1'((MOTOR_COUNT - 1) % 2))
    else $error("last flag on the wrong motor");

  // No result comes out of reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind encoder_pi_speed_control spc_checker u_spc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_motor_index (out_motor_index),
  .out_duty        (out_duty),
  .out_last        (out_last)
);
